### design/keyframe_vec3_interpolation_unit_assert.svh
// ----------------------------------------------------------------------------
// Keyframe interpolation assertion macros
// Shared forms for the concurrent checks on the keyframe interpolation unit.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_VEC3_INTERPOLATION_UNIT_ASSERT_SVH
`define KEYFRAME_VEC3_INTERPOLATION_UNIT_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define KVI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property whose consequent must hold in the cycle after its antecedent.
`define KVI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/kvi_pkg.sv
// ----------------------------------------------------------------------------
// Keyframe interpolation package
// Shared types and constants of the keyframe interpolation unit.
// ----------------------------------------------------------------------------
package kvi_pkg;

  localparam int MAX_KEYS_DEFAULT = 64;

  // Request codes carried on the request type input.
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // One keyframe table entry.
  typedef struct packed {
    logic [31:0] key_time;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } key_t;

  // Divider response back to the sequencer.
  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

endpackage

### design/kvi_divider.sv
// ----------------------------------------------------------------------------
// Keyframe interpolation fraction divider
// Restoring divider that computes floor(num * 2^31 / den), one bit per cycle,
// for num <= den and den != 0.
// ----------------------------------------------------------------------------
module kvi_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [31:0]       num_i,
  input  logic [31:0]       den_i,
  output kvi_pkg::div_rsp_t rsp_o
);

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [31:0] rem_q;
  logic [31:0] quo_q;
  logic [31:0] den_q;

  logic [32:0] shifted;
  logic [32:0] diff;
  logic        ge;

  // The low word of the dividend shifts out of quo_q while quotient bits
  // shift in behind it.
  assign shifted = {rem_q, quo_q[31]};
  assign diff    = shifted - {1'b0, den_q};
  assign ge      = (shifted >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd31;
        rem_q  <= {1'b0, num_i[31:1]};
        quo_q  <= {num_i[0], 31'b0};
        den_q  <= den_i;
      end else if (busy_q) begin
        rem_q <= ge ? diff[31:0] : shifted[31:0];
        quo_q <= {quo_q[30:0], ge};
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

### design/keyframe_vec3_interpolation_unit.sv
// ----------------------------------------------------------------------------
// Keyframe vec3 interpolation unit
// Keyframe table with linear interpolation of x, y, z at a query time.
//
//   Channel   Direction  Handshake                 Content
//   request   in         start_i, busy_o           key write or sample
//   result    out        out_valid_o strobe        x, y, z, segment start
//   config    in         key_count_we_i            keys in use
//
// A key write leaves the unit idle, so busy_o stays low. A sample reads one
// table entry per cycle through the single registered read port. It ends at
// the first key when one key is in use or the query is at or before it, else
// walks the keys; once a segment is found, the bit-serial divider runs (not
// for a zero-length segment) and the shared multiplier makes three passes.
// No clearing pass follows reset. Results cannot be stalled.
// ----------------------------------------------------------------------------
module keyframe_vec3_interpolation_unit #(
  parameter int MAX_KEYS = kvi_pkg::MAX_KEYS_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               req_type_i,
  input  logic [5:0]         key_index_i,
  input  logic [31:0]        key_time_i,
  input  logic signed [31:0] value_x_i,
  input  logic signed [31:0] value_y_i,
  input  logic signed [31:0] value_z_i,
  input  logic [31:0]        query_time_i,
  input  logic               key_count_we_i,
  input  logic [6:0]         key_count_i,
  output logic               out_valid_o,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic [5:0]         segment_start_o
);

  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW = $clog2(MAX_KEYS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_SCAN,
    S_DIV,
    S_SUB,
    S_MUL,
    S_RND
  } state_e;

  typedef enum logic [1:0] {
    COMP_X,
    COMP_Y,
    COMP_Z
  } comp_e;

  state_e             state_q;
  comp_e              comp_q;
  logic [6:0]         key_count_q;
  logic [CW-1:0]      n_q;
  logic [CW-1:0]      idx_q;
  logic [31:0]        query_q;
  kvi_pkg::key_t      prev_q;
  kvi_pkg::key_t      cur_q;
  logic [5:0]         seg_idx_q;
  logic [31:0]        dt_q;
  logic [31:0]        span_q;
  logic               div_start_q;
  logic [31:0]        frac_q;
  logic signed [32:0] diff_q;
  logic [31:0]        base_q;
  logic [62:0]        prod_q;
  logic               out_valid_q;
  logic [31:0]        out_x_q;
  logic [31:0]        out_y_q;
  logic [31:0]        out_z_q;
  logic [5:0]         out_seg_q;

  kvi_pkg::key_t      key_mem [MAX_KEYS];
  kvi_pkg::key_t      rd_data_q;
  logic [AW-1:0]      rd_addr;

  logic [CW-1:0]      idx_nxt;
  logic [CW-1:0]      n_clamp;
  logic               wr_en;
  logic [31:0]        comp_a;
  logic [31:0]        comp_b;
  logic signed [65:0] mul_w;
  logic [62:0]        rnd_w;
  logic [31:0]        blend_w;
  kvi_pkg::div_rsp_t  div_rsp;

  assign busy_o  = (state_q != S_IDLE);
  assign idx_nxt = idx_q + CW'(1);
  assign wr_en   = start_i && !busy_o && (req_type_i == kvi_pkg::REQ_WRITE) &&
                   (int'(key_index_i) < MAX_KEYS);

  always_comb begin
    if (key_count_q == '0) begin
      n_clamp = CW'(1);
    end else if (int'(key_count_q) > MAX_KEYS) begin
      n_clamp = CW'(MAX_KEYS);
    end else begin
      n_clamp = CW'(key_count_q);
    end
  end

  // The walk always fetches the entry after the current index.
  always_comb begin
    unique case (state_q) inside
      S_FIRST, S_SCAN: rd_addr = idx_nxt[AW-1:0];
      default:         rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[AW'(key_index_i)] <= '{key_time: key_time_i, x: value_x_i,
                                     y: value_y_i, z: value_z_i};
    end
    rd_data_q <= key_mem[rd_addr];
  end

  kvi_divider u_kvi_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (dt_q),
    .den_i   (span_q),
    .rsp_o   (div_rsp)
  );

  always_comb begin
    unique case (comp_q)
      COMP_X: begin
        comp_a = prev_q.x;
        comp_b = cur_q.x;
      end
      COMP_Y: begin
        comp_a = prev_q.y;
        comp_b = cur_q.y;
      end
      default: begin
        comp_a = prev_q.z;
        comp_b = cur_q.z;
      end
    endcase
  end

  // Rounding adds one half of the Q1.31 step; the arithmetic shift by 31
  // then floors, which rounds halves toward positive infinity.
  assign mul_w   = diff_q * $signed({1'b0, frac_q});
  assign rnd_w   = prod_q + (63'(1) << 30);
  assign blend_w = base_q + rnd_w[62:31];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      comp_q      <= COMP_X;
      key_count_q <= 7'd1;
      out_valid_q <= 1'b0;
      div_start_q <= 1'b0;
    end else begin
      out_valid_q <= 1'b0;
      div_start_q <= 1'b0;
      if (key_count_we_i) begin
        key_count_q <= key_count_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (start_i && (req_type_i == kvi_pkg::REQ_SAMPLE)) begin
            query_q <= query_time_i;
            n_q     <= n_clamp;
            idx_q   <= '0;
            state_q <= S_FIRST;
          end
        end
        S_FIRST: begin
          prev_q <= rd_data_q;
          if ((n_q == CW'(1)) || (query_q <= rd_data_q.key_time)) begin
            out_x_q     <= rd_data_q.x;
            out_y_q     <= rd_data_q.y;
            out_z_q     <= rd_data_q.z;
            out_seg_q   <= '0;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else begin
            idx_q   <= idx_nxt;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if ((prev_q.key_time <= query_q) && (query_q <= rd_data_q.key_time)) begin
            cur_q     <= rd_data_q;
            seg_idx_q <= 6'(idx_q - CW'(1));
            dt_q      <= query_q - prev_q.key_time;
            span_q    <= rd_data_q.key_time - prev_q.key_time;
            frac_q    <= '0;
            comp_q    <= COMP_X;
            if (rd_data_q.key_time != prev_q.key_time) begin
              div_start_q <= 1'b1;
              state_q     <= S_DIV;
            end else begin
              // A zero-length segment keeps the start key's value.
              state_q <= S_SUB;
            end
          end else if (idx_q == n_q - CW'(1)) begin
            out_x_q     <= rd_data_q.x;
            out_y_q     <= rd_data_q.y;
            out_z_q     <= rd_data_q.z;
            out_seg_q   <= 6'(idx_q);
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else begin
            prev_q <= rd_data_q;
            idx_q  <= idx_nxt;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            frac_q  <= div_rsp.quotient;
            state_q <= S_SUB;
          end
        end
        S_SUB: begin
          diff_q  <= $signed({comp_b[31], comp_b}) - $signed({comp_a[31], comp_a});
          base_q  <= comp_a;
          state_q <= S_MUL;
        end
        S_MUL: begin
          prod_q  <= mul_w[62:0];
          state_q <= S_RND;
        end
        S_RND: begin
          unique case (comp_q)
            COMP_X: begin
              out_x_q <= blend_w;
              comp_q  <= COMP_Y;
              state_q <= S_SUB;
            end
            COMP_Y: begin
              out_y_q <= blend_w;
              comp_q  <= COMP_Z;
              state_q <= S_SUB;
            end
            default: begin
              out_z_q     <= blend_w;
              out_seg_q   <= seg_idx_q;
              out_valid_q <= 1'b1;
              comp_q      <= COMP_X;
              state_q     <= S_IDLE;
            end
          endcase
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_x_o         = out_x_q;
  assign out_y_o         = out_y_q;
  assign out_z_o         = out_z_q;
  assign segment_start_o = out_seg_q;

endmodule

### design/kvi_checker.sv
// ----------------------------------------------------------------------------
// Keyframe interpolation port checker
// Concurrent checks on the request and result ports of the unit.
// ----------------------------------------------------------------------------
`include "keyframe_vec3_interpolation_unit_assert.svh"

module kvi_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic req_type_i,
  input logic out_valid_o
);

  logic write_acc;
  logic sample_acc;

  assign write_acc  = start_i && !busy_o && (req_type_i == kvi_pkg::REQ_WRITE);
  assign sample_acc = start_i && !busy_o && (req_type_i == kvi_pkg::REQ_SAMPLE);

  // A key write completes in its own cycle and never occupies the unit.
  `KVI_ASSERT_NEXT(a_write_no_busy, write_acc, !busy_o && !out_valid_o, "key write busy")

  // A sample transaction always occupies the unit in the following cycle.
  `KVI_ASSERT_NEXT(a_sample_busy, sample_acc, busy_o, "sample transaction not busy")

  // A result is shown only once the unit has returned to idle.
  `KVI_ASSERT_ALWAYS(a_result_idle, !out_valid_o || !busy_o, "result strobe while busy")

  // Each sample gives a single one-cycle strobe.
  `KVI_ASSERT_NEXT(a_single_strobe, out_valid_o, !out_valid_o, "result strobe held")

endmodule

bind keyframe_vec3_interpolation_unit kvi_checker u_kvi_checker (.*);
